// ----- rtl/grrcp_pkg.sv -----
// grrcp_pkg: shared constants, codes and controller/datapath types of the cpu picker
`timescale 1ns / 1ps

package grrcp_pkg;

	// cpu and group geometry
	localparam int NUM_CPUS       = 64;
	localparam int CPUS_PER_GROUP = 8;
	localparam int NUM_GROUPS     = NUM_CPUS / CPUS_PER_GROUP;
	localparam int CPU_W          = $clog2(NUM_CPUS);
	localparam int GRP_W          = $clog2(NUM_GROUPS);
	localparam int LANE_W         = $clog2(CPUS_PER_GROUP);
	localparam int NG_W           = GRP_W + 1;

	// configuration register
	localparam int             CFG_W     = 7;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// round-robin counter and its digit-serial reduction
	localparam int RR_W       = 32;
	localparam int DIGIT_W    = 4;
	localparam int SCAN_STEPS = RR_W / DIGIT_W;
	localparam int STEP_W     = $clog2(SCAN_STEPS);
	localparam int QUEUE_W    = 4;

	// request codes
	typedef enum logic [1:0] {
		ACT_SELECT      = 2'd0,
		ACT_IDLE_REPORT = 2'd1,
		ACT_ENQUEUE     = 2'd2,
		ACT_NONE        = 2'd3
	} action_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic              latch;
		logic              scan;
		logic [STEP_W-1:0] step;
		logic              pick;
		logic              finish;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic needs_search;
		logic out_blocked;
	} dp_status_t;

endpackage

// ----- rtl/grrcp_ctrl.sv -----
// grrcp_ctrl: sequencing state machine of the cpu picker
`timescale 1ns / 1ps

module grrcp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  grrcp_pkg::dp_status_t  status,
	output logic                   in_stall,
	output grrcp_pkg::ctrl_cmd_t   cmd
);

	grrcp_pkg::state_t                 state_q;
	grrcp_pkg::state_t                 state_d;
	logic [grrcp_pkg::STEP_W-1:0]      step_q;
	logic [grrcp_pkg::STEP_W-1:0]      step_d;

	// state and step counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grrcp_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		cmd        = '0;
		cmd.step   = step_q;
		in_stall   = 1'b1;
		case (state_q)
			grrcp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				step_d   = '0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = status.needs_search ? grrcp_pkg::ST_SCAN : grrcp_pkg::ST_DONE;
				end
			end
			grrcp_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				step_d   = step_q + 1'b1;
				if (step_q == grrcp_pkg::STEP_W'(grrcp_pkg::SCAN_STEPS - 1)) begin
					state_d = grrcp_pkg::ST_PICK;
				end
			end
			grrcp_pkg::ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = grrcp_pkg::ST_DONE;
			end
			grrcp_pkg::ST_DONE: begin
				if (!status.out_blocked) begin
					cmd.finish = 1'b1;
					state_d    = grrcp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = grrcp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/grrcp_dp.sv -----
// grrcp_dp: state registers, counter reduction, group probe and cpu claim of the picker
`timescale 1ns / 1ps

module grrcp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grrcp_pkg::ctrl_cmd_t                cmd,
	output grrcp_pkg::dp_status_t               status,
	input  logic                                cfg_we,
	input  logic [grrcp_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [1:0]                          action,
	input  logic                                eligible,
	input  logic [grrcp_pkg::NUM_CPUS-1:0]      affinity_mask,
	input  logic [grrcp_pkg::CPU_W-1:0]         cpu,
	input  logic                                idle_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                cpu_found,
	output logic [grrcp_pkg::CPU_W-1:0]         chosen_cpu,
	output logic                                group_found,
	output logic [grrcp_pkg::QUEUE_W-1:0]       queue_id
);

	// lowest set bit of one group-sized slice
	function automatic logic [grrcp_pkg::LANE_W-1:0] first_set(
		input logic [grrcp_pkg::CPUS_PER_GROUP-1:0] v
	);
		logic [grrcp_pkg::LANE_W-1:0] r;
		r = '0;
		for (int i = grrcp_pkg::CPUS_PER_GROUP - 1; i >= 0; i--) begin
			if (v[i]) r = grrcp_pkg::LANE_W'(i);
		end
		return r;
	endfunction

	// architectural state
	logic [grrcp_pkg::CFG_W-1:0]     cfg_q;
	logic [grrcp_pkg::RR_W-1:0]      rr_q;
	logic [grrcp_pkg::NUM_CPUS-1:0]  idle_q;

	// latched item
	grrcp_pkg::action_t              act_q;
	logic                            srch_q;
	logic [grrcp_pkg::NUM_CPUS-1:0]  mask_q;
	logic [grrcp_pkg::CPU_W-1:0]     cpu_q;
	logic                            idlev_q;

	// working registers
	logic [grrcp_pkg::GRP_W-1:0]     rem_q;
	logic [grrcp_pkg::CPU_W-1:0]     low_q;
	logic                            low_hit_q;
	logic [grrcp_pkg::GRP_W-1:0]     grp_q;
	logic                            gfound_q;

	// output register
	logic                            out_valid_q;
	logic                            found_q;
	logic [grrcp_pkg::CPU_W-1:0]     chosen_q;
	logic                            gout_q;
	logic [grrcp_pkg::QUEUE_W-1:0]   queue_q;

	logic [grrcp_pkg::CFG_W-1:0]     m;
	logic [grrcp_pkg::CFG_W-1:0]     m_round;
	logic [grrcp_pkg::NG_W-1:0]      ng;
	logic [grrcp_pkg::NUM_CPUS-1:0]  present;
	logic [grrcp_pkg::NUM_GROUPS-1:0] allowed;

	logic [grrcp_pkg::DIGIT_W-1:0]   digit;
	logic [grrcp_pkg::GRP_W-1:0]     rem_d;
	logic [grrcp_pkg::CPUS_PER_GROUP-1:0] slice;

	logic [grrcp_pkg::GRP_W-1:0]     probe_grp;
	logic                            probe_hit;
	logic [grrcp_pkg::GRP_W-1:0]     pick_grp;
	logic                            pick_hit;
	logic                            pick_adv;

	logic                            prev_direct;
	logic [grrcp_pkg::CPU_W-1:0]     prev;
	logic                            prev_claim;
	logic [grrcp_pkg::CPUS_PER_GROUP-1:0] cand;
	logic                            res_found;
	logic [grrcp_pkg::CPU_W-1:0]     res_cpu;
	logic                            is_sel;
	logic                            is_enq;

	// effective cpu count, group count and present cpus
	always_comb begin
		m       = (cfg_q > grrcp_pkg::CFG_W'(grrcp_pkg::NUM_CPUS)) ?
			grrcp_pkg::CFG_W'(grrcp_pkg::NUM_CPUS) : cfg_q;
		m_round = m + grrcp_pkg::CFG_W'(grrcp_pkg::CPUS_PER_GROUP - 1);
		ng      = grrcp_pkg::NG_W'(m_round >> grrcp_pkg::LANE_W);
		for (int c = 0; c < grrcp_pkg::NUM_CPUS; c++) begin
			present[c] = (grrcp_pkg::CFG_W'(c) < m);
		end
		for (int g = 0; g < grrcp_pkg::NUM_GROUPS; g++) begin
			allowed[g] = |(mask_q[g*grrcp_pkg::CPUS_PER_GROUP +: grrcp_pkg::CPUS_PER_GROUP] &
				present[g*grrcp_pkg::CPUS_PER_GROUP +: grrcp_pkg::CPUS_PER_GROUP]);
		end
	end

	// one counter digit per step: remainder modulo the group count
	always_comb begin
		logic [grrcp_pkg::GRP_W:0] t;
		logic [grrcp_pkg::GRP_W-1:0] r;
		digit = rr_q[{~cmd.step, 2'b00} +: grrcp_pkg::DIGIT_W];
		r     = (cmd.step == '0) ? '0 : rem_q;
		for (int j = grrcp_pkg::DIGIT_W - 1; j >= 0; j--) begin
			t = {r, digit[j]};
			if (ng != '0 && t >= ng) t = t - ng;
			r = t[grrcp_pkg::GRP_W-1:0];
		end
		rem_d = r;
		slice = mask_q[{cmd.step, 3'b000} +: grrcp_pkg::CPUS_PER_GROUP];
	end

	// forward cyclic probe from the remainder, and the enqueue preference
	always_comb begin
		logic [grrcp_pkg::NG_W-1:0] idx;
		logic [grrcp_pkg::GRP_W-1:0] pg;
		probe_grp = '0;
		probe_hit = 1'b0;
		for (int i = 0; i < grrcp_pkg::NUM_GROUPS; i++) begin
			idx = grrcp_pkg::NG_W'(rem_q) + grrcp_pkg::NG_W'(i);
			if (idx >= ng) idx = idx - ng;
			if (!probe_hit && grrcp_pkg::NG_W'(i) < ng &&
				allowed[idx[grrcp_pkg::GRP_W-1:0]]) begin
				probe_hit = 1'b1;
				probe_grp = idx[grrcp_pkg::GRP_W-1:0];
			end
		end
		pg = cpu_q[grrcp_pkg::CPU_W-1 -: grrcp_pkg::GRP_W];
		if (act_q == grrcp_pkg::ACT_ENQUEUE && {1'b0, pg} < ng && allowed[pg]) begin
			pick_grp = pg;
			pick_hit = 1'b1;
			pick_adv = 1'b0;
		end else begin
			pick_grp = probe_grp;
			pick_hit = probe_hit;
			pick_adv = (ng != '0);
		end
	end

	// claim in the chosen group, previous cpu first
	always_comb begin
		logic [grrcp_pkg::CPU_W-1:0] c;
		prev_direct = mask_q[cpu_q];
		prev        = prev_direct ? cpu_q : low_q;
		prev_claim  = (prev_direct || low_hit_q) && ({1'b0, prev} < m) &&
			(prev[grrcp_pkg::CPU_W-1 -: grrcp_pkg::GRP_W] == grp_q) && idle_q[prev];
		for (int i = 0; i < grrcp_pkg::CPUS_PER_GROUP; i++) begin
			c       = {grp_q, grrcp_pkg::LANE_W'(i)};
			cand[i] = mask_q[c] & present[c] & idle_q[c];
		end
		is_sel = srch_q && act_q == grrcp_pkg::ACT_SELECT;
		is_enq = srch_q && act_q == grrcp_pkg::ACT_ENQUEUE;
		if (prev_claim) begin
			res_found = 1'b1;
			res_cpu   = prev;
		end else begin
			res_found = |cand;
			res_cpu   = (|cand) ? {grp_q, first_set(cand)} : '0;
		end
		res_found = res_found && is_sel && gfound_q;
		if (!res_found) res_cpu = '0;
	end

	// architectural state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= grrcp_pkg::CFG_RESET;
			rr_q        <= '0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (cmd.pick && pick_adv) rr_q <= rr_q + 1'b1;
			if (cmd.finish) begin
				if (act_q == grrcp_pkg::ACT_IDLE_REPORT) idle_q[cpu_q] <= idlev_q;
				if (res_found) idle_q[res_cpu] <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item latch, working registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q   <= grrcp_pkg::action_t'(action);
			srch_q  <= status.needs_search;
			mask_q  <= affinity_mask;
			cpu_q   <= cpu;
			idlev_q <= idle_value;
		end
		if (cmd.scan) begin
			rem_q <= rem_d;
			// first step restarts the search for the lowest allowed cpu
			if (cmd.step == '0 || !low_hit_q) begin
				low_hit_q <= |slice;
				if (|slice) low_q <= {cmd.step, first_set(slice)};
			end
		end
		if (cmd.pick) begin
			grp_q    <= pick_grp;
			gfound_q <= pick_hit;
		end
		if (cmd.finish) begin
			found_q  <= res_found;
			chosen_q <= res_cpu;
			gout_q   <= (is_sel || is_enq) && gfound_q;
			queue_q  <= (is_enq && gfound_q) ?
				grrcp_pkg::QUEUE_W'({1'b0, grp_q} + 1'b1) : '0;
		end
	end

	// status towards the controller
	always_comb begin
		status.needs_search = eligible &&
			(action == grrcp_pkg::ACT_SELECT || action == grrcp_pkg::ACT_ENQUEUE);
		status.out_blocked  = out_valid_q && out_stall;
	end

	assign out_valid   = out_valid_q;
	assign cpu_found   = found_q;
	assign chosen_cpu  = chosen_q;
	assign group_found = gout_q;
	assign queue_id    = queue_q;

endmodule

// ----- rtl/grouped_round_robin_cpu_picker_core.sv -----
// Grouped round-robin cpu picker: places tasks on cpus split into groups of eight.
//
// Input channel (in_valid / in_stall) carries one request item: action, eligible,
// affinity_mask, cpu and idle_value. Output channel (out_valid / out_stall) returns
// exactly one result item per request: cpu_found, chosen_cpu, group_found, queue_id.
// cfg_we / cfg_wdata write cpus_in_use; write it only while no request is in flight.
// Select and enqueue requests of an eligible task go from acceptance through the scan
// state, which reduces the 32-bit round-robin counter modulo the group count,
// four bits a cycle (the lowest allowed cpu is found alongside, one byte a cycle),
// then the pick state probes the groups and the done state claims the cpu. Idle
// reports, ineligible tasks and unused actions skip scan and pick. A new item is accepted in the cycle after
// the previous one has been written to the output register.
// Reset clears all idle bits and the counter and sets cpus_in_use to 64. If the
// receiver stalls, the result waits in the output register; the next item is still
// taken and worked on, and it waits to finish until that register has been taken.
`timescale 1ns / 1ps

module grouped_round_robin_cpu_picker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [grrcp_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          action,
	input  logic                                eligible,
	input  logic [grrcp_pkg::NUM_CPUS-1:0]      affinity_mask,
	input  logic [grrcp_pkg::CPU_W-1:0]         cpu,
	input  logic                                idle_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                cpu_found,
	output logic [grrcp_pkg::CPU_W-1:0]         chosen_cpu,
	output logic                                group_found,
	output logic [grrcp_pkg::QUEUE_W-1:0]       queue_id
);

	grrcp_pkg::ctrl_cmd_t  cmd;
	grrcp_pkg::dp_status_t status;

	// sequencer
	grrcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// datapath
	grrcp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.action        (action),
		.eligible      (eligible),
		.affinity_mask (affinity_mask),
		.cpu           (cpu),
		.idle_value    (idle_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cpu_found     (cpu_found),
		.chosen_cpu    (chosen_cpu),
		.group_found   (group_found),
		.queue_id      (queue_id)
	);

endmodule

// ----- rtl/grrcp_chk.sv -----
// grrcp_chk: port-level checks of the cpu picker and their bind
`timescale 1ns / 1ps

module grrcp_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                cpu_found,
	input logic [grrcp_pkg::CPU_W-1:0]         chosen_cpu,
	input logic                                group_found,
	input logic [grrcp_pkg::QUEUE_W-1:0]       queue_id
);

	// one item at a time: an accepted item blocks the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after an item was accepted");

	// no claim means cpu zero
	a_no_claim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cpu_found |-> chosen_cpu == '0)
		else $error("chosen_cpu set without a claim");

	// a claim or a group queue needs a chosen group
	a_claim_has_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cpu_found || queue_id != '0) |-> group_found)
		else $error("claim or queue reported without a group");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chosen_cpu) && $stable(queue_id))
		else $error("stalled result changed");

endmodule

bind grouped_round_robin_cpu_picker_core grrcp_chk u_grrcp_chk (.*);

// ----- tb/sv/tb.sv -----
// tb: directed and randomised check of the grouped round-robin cpu picker against an in-bench predictor
`timescale 1ns / 1ps

module tb;
	import grrcp_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 158;

	// one request item and the result it yields
	typedef struct {
		action_t           act;
		logic              elig;
		logic [NUM_CPUS-1:0] mask;
		logic [CPU_W-1:0]  cpu;
		logic              idle;
	} sched_req_t;

	typedef struct packed {
		logic               found;
		logic [CPU_W-1:0]   chosen;
		logic               gfound;
		logic [QUEUE_W-1:0] qid;
	} pick_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata     = '0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic [1:0]          action        = '0;
	logic                eligible      = 1'b0;
	logic [NUM_CPUS-1:0] affinity_mask = '0;
	logic [CPU_W-1:0]    cpu           = '0;
	logic                idle_value    = 1'b0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic                cpu_found;
	logic [CPU_W-1:0]    chosen_cpu;
	logic                group_found;
	logic [QUEUE_W-1:0]  queue_id;

	// predictor state
	logic [RR_W-1:0]     rr_count   = '0;
	logic [NUM_CPUS-1:0] idle_cpus  = '0;
	logic [CFG_W-1:0]    cpus_cfg   = CFG_RESET;

	sched_req_t pending_reqs[$];
	pick_t      expected_picks[$];
	sched_req_t cur_req;

	bit noisy        = 1'b1;
	int send_gap     = 0;
	int recv_gap     = 0;
	int squeeze      = 0;
	int quiet_cycles = 0;
	int n_sent       = 0;
	int n_results    = 0;
	int n_claims     = 0;
	int n_queued     = 0;
	int n_cfg        = 0;
	int n_errors     = 0;

	grouped_round_robin_cpu_picker_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.eligible      (eligible),
		.affinity_mask (affinity_mask),
		.cpu           (cpu),
		.idle_value    (idle_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cpu_found     (cpu_found),
		.chosen_cpu    (chosen_cpu),
		.group_found   (group_found),
		.queue_id      (queue_id)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// true if group g holds a cpu below ncpu that the mask allows
	function automatic bit group_open(input logic [NUM_CPUS-1:0] mask, input int g,
			input int ncpu);
		int c;
		for (int i = 0; i < CPUS_PER_GROUP; i++) begin
			c = g * CPUS_PER_GROUP + i;
			if (c >= ncpu)
				break;
			if (mask[c])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// round-robin group choice, probing forward from counter mod group count
	function automatic bit rotate_group(input logic [NUM_CPUS-1:0] mask, input int ncpu,
			input int ngrp, output int g);
		int start;
		int nxt;
		g = 0;
		if (ngrp == 0)
			return 1'b0;
		start = int'(rr_count % RR_W'(ngrp));
		rr_count = rr_count + 1'b1;
		for (int i = 0; i < ngrp; i++) begin
			nxt = start + i;
			if (nxt >= ngrp)
				nxt -= ngrp;
			if (group_open(mask, nxt, ncpu)) begin
				g = nxt;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// placement decision for one request, updating the predicted state
	function automatic pick_t place_task(input sched_req_t r);
		pick_t res;
		int    ncpu;
		int    ngrp;
		int    prev;
		int    g;
		int    c;
		bit    prev_ok;
		res  = '0;
		ncpu = (cpus_cfg > NUM_CPUS) ? NUM_CPUS : int'(cpus_cfg);
		ngrp = (ncpu + CPUS_PER_GROUP - 1) / CPUS_PER_GROUP;
		case (r.act)
			ACT_IDLE_REPORT: begin
				idle_cpus[r.cpu] = r.idle;
			end
			ACT_SELECT: begin
				if (r.elig) begin
					prev    = r.cpu;
					prev_ok = r.mask[r.cpu];
					// lowest allowed cpu stands in for a disallowed previous one
					if (!prev_ok && r.mask != '0) begin
						for (int i = NUM_CPUS - 1; i >= 0; i--)
							if (r.mask[i])
								prev = i;
						prev_ok = 1'b1;
					end
					if (rotate_group(r.mask, ncpu, ngrp, g)) begin
						res.gfound = 1'b1;
						if (prev_ok && prev < ncpu && prev / CPUS_PER_GROUP == g &&
								idle_cpus[prev]) begin
							idle_cpus[prev] = 1'b0;
							res.found       = 1'b1;
							res.chosen      = CPU_W'(prev);
						end else begin
							for (int i = 0; i < CPUS_PER_GROUP; i++) begin
								c = g * CPUS_PER_GROUP + i;
								if (c >= ncpu)
									break;
								if (r.mask[c] && idle_cpus[c]) begin
									idle_cpus[c] = 1'b0;
									res.found    = 1'b1;
									res.chosen   = CPU_W'(c);
									break;
								end
							end
						end
					end
				end
			end
			ACT_ENQUEUE: begin
				if (r.elig) begin
					g = r.cpu / CPUS_PER_GROUP;
					if (g < ngrp && group_open(r.mask, g, ncpu))
						res.gfound = 1'b1;
					else if (rotate_group(r.mask, ncpu, ngrp, g))
						res.gfound = 1'b1;
					if (res.gfound)
						res.qid = QUEUE_W'(g + 1);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [NUM_CPUS-1:0] random_mask();
		case ($urandom_range(0, 9))
			0:       return '1;
			1:       return '0;
			2, 3:    return {$urandom, $urandom};
			4, 5:    return 64'd1 << $urandom_range(0, NUM_CPUS - 1);
			6, 7:    return 64'(8'($urandom)) << (CPUS_PER_GROUP * $urandom_range(0, 7));
			8:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return {$urandom, $urandom} & ~(64'h1 << $urandom_range(0, 63)) &
				{$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0, 32'h0};
		endcase
	endfunction

	// idle reports and selects in equal share, fewer enqueues, a little noise
	function automatic sched_req_t random_req();
		sched_req_t r;
		int roll;
		roll   = $urandom_range(0, 19);
		r.mask = random_mask();
		r.elig = ($urandom_range(0, 9) != 0);
		r.idle = ($urandom_range(0, 3) != 0);
		r.cpu  = CPU_W'($urandom_range(0, NUM_CPUS - 1));
		if (r.mask != '0 && $urandom_range(0, 1))
			while (!r.mask[r.cpu])
				r.cpu = CPU_W'($urandom_range(0, NUM_CPUS - 1));
		if (roll < 7)
			r.act = ACT_IDLE_REPORT;
		else if (roll < 14)
			r.act = ACT_SELECT;
		else if (roll < 19)
			r.act = ACT_ENQUEUE;
		else
			r.act = ACT_NONE;
		return r;
	endfunction

	task automatic add_req(input action_t a, input logic e, input logic [NUM_CPUS-1:0] m,
			input int c, input logic v);
		sched_req_t r;
		r.act  = a;
		r.elig = e;
		r.mask = m;
		r.cpu  = CPU_W'(c);
		r.idle = v;
		pending_reqs.push_back(r);
	endtask

	// wait until every item is sent and every result back, then let the block go quiet
	task automatic settle();
		while (pending_reqs.size() != 0 || in_valid || expected_picks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_picks.push_back(place_task(cur_req));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (noisy && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					in_valid      <= 1'b1;
					action        <= cur_req.act;
					eligible      <= cur_req.elig;
					affinity_mask <= cur_req.mask;
					cpu           <= cur_req.cpu;
					idle_value    <= cur_req.idle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		pick_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_picks.size() == 0) begin
					$error("result item with no expectation waiting");
					n_errors++;
				end else begin
					want = expected_picks.pop_front();
					if (want.found)
						n_claims++;
					if (want.qid != '0)
						n_queued++;
					if (cpu_found !== want.found) begin
						$error("cpu_found: expected %0d, got %0d", want.found, cpu_found);
						n_errors++;
					end
					if (chosen_cpu !== want.chosen) begin
						$error("chosen_cpu: expected %0d, got %0d", want.chosen, chosen_cpu);
						n_errors++;
					end
					if (group_found !== want.gfound) begin
						$error("group_found: expected %0d, got %0d", want.gfound,
							group_found);
						n_errors++;
					end
					if (queue_id !== want.qid) begin
						$error("queue_id: expected %0d, got %0d", want.qid, queue_id);
						n_errors++;
					end
				end
				// long hold-off so the block backs up into its input
				if (n_results == 300 || n_results == 800)
					squeeze = 160;
			end
			if (squeeze > 0) begin
				squeeze--;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else if (noisy && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	// stimulus phases with cpus_in_use changes in between
	initial begin
		int cfg_plan[PHASES];
		cfg_plan = '{64, 1, 8, 9, 0, 127, 20, 64, 57, 33};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening at reset configuration
		add_req(ACT_SELECT,      1'b1, '1,              0,  1'b0);
		add_req(ACT_ENQUEUE,     1'b1, '1,              63, 1'b0);
		add_req(ACT_IDLE_REPORT, 1'b0, '0,              0,  1'b1);
		add_req(ACT_IDLE_REPORT, 1'b1, '1,              63, 1'b1);
		add_req(ACT_IDLE_REPORT, 1'b1, '0,              9,  1'b1);
		add_req(ACT_SELECT,      1'b1, '1,              9,  1'b0);
		add_req(ACT_SELECT,      1'b1, 64'h1 << 63,     5,  1'b0);
		add_req(ACT_SELECT,      1'b1, '0,              3,  1'b0);
		add_req(ACT_ENQUEUE,     1'b1, '0,              3,  1'b0);
		add_req(ACT_SELECT,      1'b0, '1,              0,  1'b1);
		add_req(ACT_ENQUEUE,     1'b0, '1,              0,  1'b1);
		add_req(ACT_NONE,        1'b1, '1,              63, 1'b1);
		add_req(ACT_IDLE_REPORT, 1'b1, '1,              0,  1'b0);
		add_req(ACT_ENQUEUE,     1'b1, 64'hff << 40,    0,  1'b0);
		for (int c = 0; c < CPUS_PER_GROUP; c++)
			add_req(ACT_IDLE_REPORT, 1'b1, '1, c, 1'b1);
		add_req(ACT_SELECT,      1'b1, 64'h0f,          60, 1'b0);
		add_req(ACT_SELECT,      1'b1, 64'hf0,          6,  1'b0);
		add_req(ACT_ENQUEUE,     1'b1, 64'h1,           7,  1'b0);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle();
				noisy = !(p == 4 || p >= PHASES - 2);
				cfg_we    <= 1'b1;
				cfg_wdata <= CFG_W'(cfg_plan[p]);
				@(posedge clk);
				cfg_we   <= 1'b0;
				cpus_cfg = CFG_W'(cfg_plan[p]);
				n_cfg++;
				@(negedge clk);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_reqs.push_back(random_req());
		end

		settle();
		$display("sent %0d items over %0d cpus_in_use settings, checked %0d results",
			n_sent, n_cfg + 1, n_results);
		$display("%0d cpus claimed, %0d tasks given a group queue", n_claims, n_queued);
		if (n_errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/grrcp_pkg.sv
rtl/grrcp_ctrl.sv
rtl/grrcp_dp.sv
rtl/grouped_round_robin_cpu_picker_core.sv
rtl/grrcp_chk.sv
tb/sv/tb.sv
